/* sv/sdre_pkg.sv */
// ----------------------------------------------------------------------------
// sdre_pkg
// Shared types and constants of the signed radix digit emitter.
// ----------------------------------------------------------------------------
package sdre_pkg;

  localparam int CHAR_W    = 8;
  localparam int POS_W     = 6;
  localparam int RADIX_W   = 5;
  localparam int DIGIT_W   = 4;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W = 2;
  localparam int STEP_BITS = 8;

  localparam logic [CFG_IDX_W-1:0] REG_RADIX      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_HIGH = 2'd2;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
  localparam logic [RADIX_W-1:0] MIN_RADIX   = 5'd2;
  localparam logic [RADIX_W-1:0] MAX_RADIX   = 5'd16;

  localparam logic [CHAR_W-1:0] ZERO_CHAR  = 8'h30;
  localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;

  typedef struct packed {
    logic load;
    logic div_step;
    logic emit_zero;
    logic emit_sign;
    logic rd_issue;
    logic emit_digit;
  } sdre_cmd_t;

  typedef struct packed {
    logic in_zero;
    logic div_last;
    logic quot_zero;
    logic neg;
    logic out_free;
    logic count_one;
  } sdre_status_t;

endpackage

/* sv/sdre_if.sv */
// ----------------------------------------------------------------------------
// sdre_if
// Valid/ready channels of the emitter: the value in and the characters out.
// ----------------------------------------------------------------------------
interface sdre_in_if #(
  parameter int VALUE_WIDTH = 32
) ();
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sdre_out_if import sdre_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic [POS_W-1:0]  position;
  logic              last;

  modport source (output valid, output character, output position, output last,
                  input ready);
  modport sink   (input valid, input character, input position, input last,
                  output ready);
endinterface

/* sv/signed_radix_digit_emitter_unit.sv */
// ----------------------------------------------------------------------------
// signed_radix_digit_emitter_unit
// Converts a signed integer to text in a configured radix, one character
// per item, most significant first.
// ----------------------------------------------------------------------------
//   channel  | role | payload
//   ---------+------+----------------------------------------
//   in_ch    | sink | value (VALUE_WIDTH bits, signed)
//   out_ch   | src  | character (8), position (6), last (1)
//   cfg_*    | sink | write enable, register index, 64-bit data
//
// one item at a time; the remainder unit divides eight dividend bits per step
// for each digit, and each character is read from the digit store before it
// is shown; the sign step is taken with or without a minus; a zero value
// emits the single character 0
// synchronous active-high reset; radix returns to 10, alphabet to zero bytes
// a stalled output holds the character; the next value is taken once the
// last character sits in the output register
// ----------------------------------------------------------------------------
module signed_radix_digit_emitter_unit import sdre_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  sdre_in_if.sink               in_ch,
  sdre_out_if.source            out_ch
);

  sdre_cmd_t    cmd;
  sdre_status_t status;
  logic         ready;

  assign in_ch.ready = ready;

  sdre_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (ready),
    .status   (status),
    .cmd      (cmd)
  );

  sdre_dp #(.VALUE_WIDTH(VALUE_WIDTH)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_value      (in_ch.value),
    .out_ready     (out_ch.ready),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (out_ch.valid),
    .out_character (out_ch.character),
    .out_position  (out_ch.position),
    .out_last      (out_ch.last)
  );

endmodule

/* sv/sdre_div.sv */
// ----------------------------------------------------------------------------
// sdre_div
// Shared remainder unit: divides the working magnitude by the radix, eight
// dividend bits per cycle, and leaves the quotient in place for the next digit.
// ----------------------------------------------------------------------------
module sdre_div import sdre_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  logic [VALUE_WIDTH-1:0] load_value,
  input  logic                   step,
  input  logic [RADIX_W-1:0]     divisor,
  output logic                   last,
  output logic [DIGIT_W-1:0]     digit,
  output logic                   quot_zero
);

  localparam int PW  = ((VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
  localparam int NCH = PW / STEP_BITS;
  localparam int CHW = (NCH > 1) ? $clog2(NCH) : 1;

  logic [PW-1:0]      work;
  logic [PW-1:0]      work_next;
  logic [RADIX_W-1:0] rem;
  logic [RADIX_W-1:0] rem_next;
  logic [CHW-1:0]     chunk;

  // eight restoring steps on a remainder that never reaches 16
  always_comb begin
    logic [RADIX_W-1:0]   r;
    logic [STEP_BITS-1:0] t;
    logic [STEP_BITS-1:0] q;
    r = rem;
    t = work[PW-1 -: STEP_BITS];
    q = '0;
    for (int i = STEP_BITS - 1; i >= 0; i--) begin
      r = {r[RADIX_W-2:0], t[i]};
      if (r >= divisor) begin
        r    = r - divisor;
        q[i] = 1'b1;
      end
    end
    rem_next  = r;
    work_next = (work << STEP_BITS) | PW'(q);
  end

  assign last      = (chunk == CHW'(NCH - 1));
  assign digit     = rem_next[DIGIT_W-1:0];
  assign quot_zero = (work_next == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk <= '0;
      rem   <= '0;
    end else if (load) begin
      chunk <= '0;
      rem   <= '0;
    end else if (step) begin
      chunk <= last ? '0 : chunk + 1'b1;
      rem   <= last ? '0 : rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      work <= PW'(load_value);
    end else if (step) begin
      work <= work_next;
    end
  end

endmodule

/* sv/sdre_dp.sv */
// ----------------------------------------------------------------------------
// sdre_dp
// Datapath: configuration registers, magnitude, digit store and output stage.
// ----------------------------------------------------------------------------
module sdre_dp import sdre_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic [VALUE_WIDTH-1:0] in_value,
  input  logic                   out_ready,
  input  sdre_cmd_t              cmd,
  output sdre_status_t           status,
  output logic                   out_valid,
  output logic [CHAR_W-1:0]      out_character,
  output logic [POS_W-1:0]       out_position,
  output logic                   out_last
);

  localparam int AW = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
  localparam int CW = $clog2(VALUE_WIDTH + 1);

  logic [RADIX_W-1:0]    radix;
  logic [CFG_DATA_W-1:0] digit_chars_low;
  logic [CFG_DATA_W-1:0] digit_chars_high;
  logic                  negative_flag;
  logic [CW-1:0]         digit_count;
  logic [CW-1:0]         count_dec;
  logic [POS_W-1:0]      position;
  logic [CHAR_W-1:0]     rd_data;
  logic [CHAR_W-1:0]     digit_store [VALUE_WIDTH];

  logic [RADIX_W-1:0]     divisor;
  logic [VALUE_WIDTH-1:0] magnitude;
  logic                   div_last;
  logic [DIGIT_W-1:0]     digit;
  logic                   quot_zero;
  logic [2*CFG_DATA_W-1:0] alphabet;
  logic [CHAR_W-1:0]      digit_char;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix            <= RADIX_RESET;
      digit_chars_low  <= '0;
      digit_chars_high <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RADIX:      radix            <= cfg_data[RADIX_W-1:0];
        REG_CHARS_LOW:  digit_chars_low  <= cfg_data;
        REG_CHARS_HIGH: digit_chars_high <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (radix < MIN_RADIX) begin
      divisor = MIN_RADIX;
    end else if (radix > MAX_RADIX) begin
      divisor = MAX_RADIX;
    end else begin
      divisor = radix;
    end
  end

  // unsigned negate keeps the most negative value exact
  assign magnitude = in_value[VALUE_WIDTH-1] ? (VALUE_WIDTH'(0) - in_value) : in_value;

  sdre_div #(.VALUE_WIDTH(VALUE_WIDTH)) u_div (
    .clk        (clk),
    .rst        (rst),
    .load       (cmd.load),
    .load_value (magnitude),
    .step       (cmd.div_step),
    .divisor    (divisor),
    .last       (div_last),
    .digit      (digit),
    .quot_zero  (quot_zero)
  );

  assign alphabet   = {digit_chars_high, digit_chars_low};
  assign digit_char = alphabet[{digit, 3'b000} +: CHAR_W];
  assign count_dec  = digit_count - 1'b1;

  // digits go in least significant first and come back out in reverse
  always_ff @(posedge clk) begin
    if (cmd.div_step && div_last) begin
      digit_store[digit_count[AW-1:0]] <= digit_char;
    end
    if (cmd.rd_issue) begin
      rd_data <= digit_store[count_dec[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count   <= '0;
      negative_flag <= 1'b0;
      position      <= '0;
    end else begin
      if (cmd.load) begin
        digit_count   <= '0;
        negative_flag <= in_value[VALUE_WIDTH-1];
        position      <= '0;
      end else begin
        if (cmd.div_step && div_last) begin
          digit_count <= digit_count + 1'b1;
        end else if (cmd.emit_digit) begin
          digit_count <= count_dec;
        end
        if (cmd.emit_sign) begin
          position <= POS_W'(1);
        end else if (cmd.emit_digit) begin
          position <= position + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_zero || cmd.emit_sign || cmd.emit_digit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_zero) begin
      out_character <= ZERO_CHAR;
      out_position  <= '0;
      out_last      <= 1'b1;
    end else if (cmd.emit_sign) begin
      out_character <= MINUS_CHAR;
      out_position  <= '0;
      out_last      <= 1'b0;
    end else if (cmd.emit_digit) begin
      out_character <= rd_data;
      out_position  <= position;
      out_last      <= (digit_count == CW'(1));
    end
  end

  assign status.in_zero   = (in_value == '0);
  assign status.div_last  = div_last;
  assign status.quot_zero = quot_zero;
  assign status.neg       = negative_flag;
  assign status.out_free  = !out_valid || out_ready;
  assign status.count_one = (digit_count == CW'(1));

endmodule

/* sv/sdre_ctrl.sv */
// ----------------------------------------------------------------------------
// sdre_ctrl
// Controller: sequences conversion, sign and digit emission for one item.
// ----------------------------------------------------------------------------
module sdre_ctrl import sdre_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  sdre_status_t status,
  output sdre_cmd_t    cmd
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_ZERO = 6'b000010,
    ST_DIV  = 6'b000100,
    ST_SIGN = 6'b001000,
    ST_READ = 6'b010000,
    ST_SHOW = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = status.in_zero ? ST_ZERO : ST_DIV;
        end
      end
      ST_ZERO: begin
        if (status.out_free) begin
          cmd.emit_zero = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last && status.quot_zero) begin
          state_next = ST_SIGN;
        end
      end
      ST_SIGN: begin
        if (!status.neg) begin
          state_next = ST_READ;
        end else if (status.out_free) begin
          cmd.emit_sign = 1'b1;
          state_next    = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd_issue = 1'b1;
        state_next   = ST_SHOW;
      end
      ST_SHOW: begin
        if (status.out_free) begin
          cmd.emit_digit = 1'b1;
          state_next     = status.count_one ? ST_IDLE : ST_READ;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* sv/sdre_chk.sv */
// ----------------------------------------------------------------------------
// sdre_chk
// Port-level checks of the emitter, bound to the top level.
// ----------------------------------------------------------------------------
module sdre_chk import sdre_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CHAR_W-1:0] out_character,
  input logic [POS_W-1:0]  out_position,
  input logic              out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      $stable(out_character) && $stable(out_position) && $stable(out_last))
    else $error("output item changed while stalled");

  // one value in flight: the block is busy right after taking an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again while converting");

  // a new value only starts once the previous text is complete
  a_text_done: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> !out_valid || out_last)
    else $error("input taken with text still pending");

endmodule

bind signed_radix_digit_emitter_unit sdre_chk u_sdre_chk (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_character (out_ch.character),
  .out_position  (out_ch.position),
  .out_last      (out_ch.last)
);
